/* hdl/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

    localparam int unsigned RunBytes   = 3;
    localparam int unsigned RunDepth   = 2;

    localparam logic [7:0] ChBackslash = 8'h5c;
    localparam logic [7:0] ChLowerU    = 8'h75;
    localparam logic [7:0] ChLowerN    = 8'h6e;
    localparam logic [7:0] ChLowerR    = 8'h72;
    localparam logic [7:0] ChLf        = 8'h0a;
    localparam logic [7:0] ChCr        = 8'h0d;

    localparam logic [15:0] Max1Byte   = 16'h007f;
    localparam logic [15:0] Max2Byte   = 16'h07ff;
    localparam logic [2:0]  Lead2      = 3'b110;
    localparam logic [3:0]  Lead3      = 4'b1110;
    localparam logic [1:0]  ContTag    = 2'b10;

    // One-hot escape phase
    typedef enum logic [5:0] {
        PH_TEXT = 6'b000001,
        PH_ESC  = 6'b000010,
        PH_HEX1 = 6'b000100,
        PH_HEX2 = 6'b001000,
        PH_HEX3 = 6'b010000,
        PH_HEX4 = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
        logic       cut_escape;
    } t_out;

    // All results caused by one input byte
    typedef struct packed {
        logic [RunBytes-1:0][7:0] bytes;
        logic [1:0]               last_idx;
        logic                     has_data;
        logic                     string_last;
        logic                     cut;
    } t_run;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/jsu_decode.sv */
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_in  i_item,
    output t_run      o_run,
    output logic      o_push
);

    t_phase      r_phase, n_phase;
    logic [11:0] r_accum, n_accum;

    logic [3:0]  hex;
    logic [15:0] code;
    logic        emits;

    always_comb begin
        hex     = hex_value(i_item.in_byte);
        code    = {r_accum, hex};
        n_phase = r_phase;
        n_accum = r_accum;
        emits   = 1'b0;
        o_run   = '0;

        unique case (r_phase)
            PH_TEXT: begin
                if (i_item.in_byte == ChBackslash) begin
                    n_phase = PH_ESC;
                end else begin
                    emits          = 1'b1;
                    o_run.bytes[0] = i_item.in_byte;
                end
            end
            PH_ESC: begin
                if (i_item.in_byte == ChLowerU) begin
                    n_phase = PH_HEX1;
                    n_accum = '0;
                end else begin
                    n_phase = PH_TEXT;
                    emits   = 1'b1;
                    if (i_item.in_byte == ChLowerN) begin
                        o_run.bytes[0] = ChLf;
                    end else if (i_item.in_byte == ChLowerR) begin
                        o_run.bytes[0] = ChCr;
                    end else begin
                        o_run.bytes[0] = i_item.in_byte;
                    end
                end
            end
            PH_HEX1: begin
                n_phase = PH_HEX2;
                n_accum = {r_accum[7:0], hex};
            end
            PH_HEX2: begin
                n_phase = PH_HEX3;
                n_accum = {r_accum[7:0], hex};
            end
            PH_HEX3: begin
                n_phase = PH_HEX4;
                n_accum = {r_accum[7:0], hex};
            end
            PH_HEX4: begin
                n_phase = PH_TEXT;
                n_accum = '0;
                emits   = 1'b1;
                if (code <= Max1Byte) begin
                    o_run.bytes[0] = code[7:0];
                    o_run.last_idx = 2'd0;
                end else if (code <= Max2Byte) begin
                    o_run.bytes[0] = {Lead2, code[10:6]};
                    o_run.bytes[1] = {ContTag, code[5:0]};
                    o_run.last_idx = 2'd1;
                end else begin
                    o_run.bytes[0] = {Lead3, code[15:12]};
                    o_run.bytes[1] = {ContTag, code[11:6]};
                    o_run.bytes[2] = {ContTag, code[5:0]};
                    o_run.last_idx = 2'd2;
                end
            end
            default: begin
                n_phase = PH_TEXT;
                n_accum = '0;
            end
        endcase

        o_run.has_data    = emits;
        o_run.string_last = i_item.string_last;
        // An unfinished escape shows only on a bare end marker
        o_run.cut         = i_item.string_last && !emits && (n_phase != PH_TEXT);
        o_push            = i_accept && (emits || i_item.string_last);

        if (i_item.string_last) begin
            n_phase = PH_TEXT;
            n_accum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_accum <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_accum <= n_accum;
        end
    end

endmodule

`default_nettype wire

/* hdl/json_string_unescape_utf8.sv */
`default_nettype none

// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+--------------------------------
// input    | in        | i_in_valid / o_in_ready  | i_in_data  (t_in: byte, last)
// output   | out       | o_out_valid / i_out_ready| o_out_data (t_out: byte, flags)
//
// One input byte per cycle while o_in_ready is high. A byte leaves 0 or 1 results,
// except the final hex digit of a \u escape, which leaves 1 to 3; the output register
// sends one result per cycle while i_out_ready is high, one run byte after another.
// A two-entry run buffer sits between decode and output; o_in_ready is high
// while it has a free entry, so input keeps flowing while a result waits.
// Reset is synchronous, active low, and clears the escape state and buffers.

module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,

    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,

    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    logic accept;
    logic push;
    t_run run;

    // Run buffer: small circular queue of decoded runs
    t_run       r_fifo [RunDepth];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count,  n_count;

    // Position inside the head run
    logic [1:0] r_idx, n_idx;

    t_out r_out, n_out;
    logic r_out_valid, n_out_valid;

    t_run head;
    logic load;
    logic pop;
    logic fin;

    assign o_in_ready = (r_count != 2'(RunDepth));
    assign accept     = i_in_valid && o_in_ready;

    jsu_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .o_run    (run),
        .o_push   (push)
    );

    always_comb begin
        head = r_fifo[r_rd_ptr];
        // Advance the output register when it is empty or being taken and a run is buffered
        load = (!r_out_valid || i_out_ready) && (r_count != 2'd0);
        fin  = (r_idx == head.last_idx);
        pop  = load && fin;

        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_idx       = r_idx;

        if (load) begin
            n_out_valid         = 1'b1;
            n_out.out_byte      = head.has_data ? head.bytes[r_idx] : 8'h00;
            n_out.byte_valid    = head.has_data;
            n_out.run_last      = fin;
            n_out.string_end    = fin && head.string_last;
            n_out.cut_escape    = fin && head.cut;
            n_idx               = fin ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        n_wr_ptr = push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? !r_rd_ptr : r_rd_ptr;
        case ({push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_count     <= 2'd0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= run;
        end
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* bench/json_string_unescape_utf8_test.sv */
`default_nettype none

module json_string_unescape_utf8_test;
    import jsu_pkg::*;

    // Bench ceiling in time units, far above the slowest legal run
    localparam int unsigned WatchdogLimit = 400000;
    // Settle time after the last expected result
    localparam int unsigned SettleCycles  = 8;
    localparam int unsigned RandomItems   = 130;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    json_string_unescape_utf8 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Decoder shadow state, advanced once per accepted input transaction
    t_phase      esc_phase = PH_TEXT;
    logic [15:0] code_bits = '0;

    // Output transactions still owed by the block, oldest first
    t_out        unescaped_due[$];
    // Bytes of the string about to be sent
    logic [7:0]  str_bytes[$];

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;

    // Map an ASCII hex digit to its value; anything else reads as zero
    function automatic logic [3:0] digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return c[3:0];
        end
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            return c[3:0] + 4'd9;
        end
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
        if (v < 4'd10) begin
            return 8'("0") + 8'(v);
        end
        return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
    endfunction

    // Advance the shadow decoder by one input byte and queue what it must emit
    function automatic void unescape_byte(input t_in item);
        logic [7:0]  emit [3];
        logic [15:0] cp;
        int          n;
        int          k;
        t_out        res;
        n = 0;
        case (esc_phase)
            PH_TEXT: begin
                if (item.in_byte == ChBackslash) begin
                    esc_phase = PH_ESC;
                end else begin
                    emit[n++] = item.in_byte;
                end
            end
            PH_ESC: begin
                if (item.in_byte == ChLowerU) begin
                    esc_phase = PH_HEX1;
                    code_bits = '0;
                end else begin
                    esc_phase = PH_TEXT;
                    if (item.in_byte == ChLowerN) begin
                        emit[n++] = ChLf;
                    end else if (item.in_byte == ChLowerR) begin
                        emit[n++] = ChCr;
                    end else begin
                        emit[n++] = item.in_byte;
                    end
                end
            end
            PH_HEX1, PH_HEX2, PH_HEX3: begin
                code_bits = {code_bits[11:0], digit_of(item.in_byte)};
                esc_phase = (esc_phase == PH_HEX1) ? PH_HEX2 :
                            (esc_phase == PH_HEX2) ? PH_HEX3 : PH_HEX4;
            end
            default: begin
                // Fourth hex digit: encode the code point as UTF-8
                cp = {code_bits[11:0], digit_of(item.in_byte)};
                if (cp <= Max1Byte) begin
                    emit[n++] = cp[7:0];
                end else if (cp <= Max2Byte) begin
                    emit[n++] = {Lead2, cp[10:6]};
                    emit[n++] = {ContTag, cp[5:0]};
                end else begin
                    emit[n++] = {Lead3, cp[15:12]};
                    emit[n++] = {ContTag, cp[11:6]};
                    emit[n++] = {ContTag, cp[5:0]};
                end
                esc_phase = PH_TEXT;
                code_bits = '0;
            end
        endcase
        for (k = 0; k < n; k++) begin
            res.out_byte   = emit[k];
            res.byte_valid = 1'b1;
            res.run_last   = (k == n - 1);
            res.string_end = (k == n - 1) && item.string_last;
            res.cut_escape = 1'b0;
            unescaped_due.push_back(res);
        end
        if (item.string_last) begin
            // A quiet final byte still closes the string with a bare marker
            if (n == 0) begin
                res.out_byte   = 8'h00;
                res.byte_valid = 1'b0;
                res.run_last   = 1'b1;
                res.string_end = 1'b1;
                res.cut_escape = (esc_phase != PH_TEXT);
                unescaped_due.push_back(res);
            end
            esc_phase = PH_TEXT;
            code_bits = '0;
        end
    endfunction

    // Offer one input transaction, hold it until taken, then maybe idle a while
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in item;
        item.in_byte     = b;
        item.string_last = last;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        unescape_byte(item);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // Mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    // Send the staged string, marking its final byte
    task automatic send_string();
        int k;
        for (k = 0; k < str_bytes.size(); k++) begin
            send_byte(str_bytes[k], k == str_bytes.size() - 1);
        end
    endtask

    // Hold off input until every owed output transaction has drained
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (unescaped_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Plain bytes at both extremes around \n, \r and an escaped backslash
    task automatic test_plain_and_escapes();
        str_bytes = {8'h00, ChBackslash, ChLowerN, ChBackslash, ChLowerR,
                     ChBackslash, ChBackslash, 8'hff};
        send_string();
        drain_results();
    endtask

    // \u: the top of the surrogate range as 3 bytes, a non-hex digit
    // that reads as zero, and the largest 2-byte code
    task automatic test_unicode();
        str_bytes = {ChBackslash, ChLowerU, 8'("D"), 8'("f"), 8'("F"), 8'("f"),
                     ChBackslash, ChLowerU, 8'("0"), 8'("7"), 8'("z"), 8'("F")};
        send_string();
        drain_results();
        str_bytes = {ChBackslash, ChLowerU, 8'("0"), 8'("7"), 8'("F"), 8'("F")};
        send_string();
        drain_results();
    endtask

    // String ends right after \u: expect a bare marker with the cut flag
    task automatic test_cut_escape();
        str_bytes = {ChBackslash, ChLowerU};
        send_string();
        drain_results();
    endtask

    // Random strings built from well-formed tokens, with noise and cut escapes
    task automatic test_random_strings();
        int unsigned first_item;
        int unsigned n_tokens;
        int unsigned t;
        int unsigned d;
        int unsigned kind;
        int unsigned strings;
        logic [15:0] cp;
        logic        cut;
        first_item = items_sent;
        strings    = 0;
        while (items_sent - first_item < RandomItems) begin
            str_bytes.delete();
            cut      = 1'b0;
            n_tokens = $urandom_range(1, 5);
            for (t = 0; t < n_tokens && !cut; t++) begin
                kind = $urandom_range(0, 9);
                if (kind <= 3) begin
                    // Any byte, a stray backslash included
                    str_bytes.push_back(8'($urandom_range(0, 255)));
                end else if (kind <= 5) begin
                    str_bytes.push_back(ChBackslash);
                    case ($urandom_range(0, 5))
                        0: str_bytes.push_back(ChLowerN);
                        1: str_bytes.push_back(ChLowerR);
                        2: str_bytes.push_back(8'h22);
                        3: str_bytes.push_back(ChBackslash);
                        4: str_bytes.push_back(8'h2f);
                        default: begin
                            str_bytes.push_back(8'($urandom_range(0, 255)));
                        end
                    endcase
                end else if (kind <= 8) begin
                    // Spread code points over all UTF-8 lengths and surrogates
                    case ($urandom_range(0, 3))
                        0: cp = 16'($urandom_range(0, 16'h007f));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07ff));
                        2: cp = 16'($urandom_range(16'h0800, 16'hffff));
                        default: cp = 16'($urandom_range(16'hd800, 16'hdfff));
                    endcase
                    str_bytes.push_back(ChBackslash);
                    str_bytes.push_back(ChLowerU);
                    for (d = 0; d < 4; d++) begin
                        if ($urandom_range(0, 6) == 0) begin
                            str_bytes.push_back(8'($urandom_range(0, 255)));
                        end else begin
                            str_bytes.push_back(hex_char(cp[15 - 4*d -: 4],
                                                         1'($urandom_range(0, 1))));
                        end
                    end
                end else begin
                    // Cut the string inside an escape
                    str_bytes.push_back(ChBackslash);
                    if ($urandom_range(0, 3) != 0) begin
                        str_bytes.push_back(ChLowerU);
                        repeat ($urandom_range(0, 3)) begin
                            str_bytes.push_back(hex_char(4'($urandom_range(0, 15)),
                                                         1'($urandom_range(0, 1))));
                        end
                    end
                    cut = 1'b1;
                end
            end
            send_string();
            strings++;
            if (strings % 8 == 0) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    // Receiver: switch among always ready, coin flip, mostly stalled and toggling
    int unsigned ready_mode = 0;
    int unsigned ready_left = 0;
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(8, 40);
        end else begin
            ready_left--;
        end
        case (ready_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= ~i_out_ready;
        endcase
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
        mismatches++;
    endtask

    // Compare each accepted output transaction with the oldest one owed
    always @(posedge i_clk) begin : check_output
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (unescaped_due.size() == 0) begin
                $display("%0t: unexpected output, expected none, actual %p",
                         $time, o_out_data);
                mismatches++;
            end else begin
                want = unescaped_due.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    report_field("out_byte", want.out_byte, o_out_data.out_byte);
                end
                if (o_out_data.byte_valid !== want.byte_valid) begin
                    report_field("byte_valid", want.byte_valid, o_out_data.byte_valid);
                end
                if (o_out_data.run_last !== want.run_last) begin
                    report_field("run_last", want.run_last, o_out_data.run_last);
                end
                if (o_out_data.string_end !== want.string_end) begin
                    report_field("string_end", want.string_end, o_out_data.string_end);
                end
                if (o_out_data.cut_escape !== want.cut_escape) begin
                    report_field("cut_escape", want.cut_escape, o_out_data.cut_escape);
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_plain_and_escapes();
        test_unicode();
        test_cut_escape();
        test_random_strings();
        if (unescaped_due.size() != 0) begin
            $display("%0t: %0d output transactions never arrived",
                     $time, unescaped_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #WatchdogLimit;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
